>>> hw/rtl/ftr_pkg.sv
package ftr_pkg;

    localparam int MAX_LOG_SIZE = 20;
    localparam int NSTEP        = MAX_LOG_SIZE - 6;   // fold stages, one per bit of lo
    localparam int IDX_W        = 18;
    localparam int LS_W         = 5;
    localparam int Q_W          = 64;

    localparam logic [LS_W-1:0] LOG_SIZE_RST = LS_W'(10);
    localparam logic [LS_W-1:0] LOG_SIZE_MIN = LS_W'(2);
    localparam logic [LS_W-1:0] LOG_SIZE_MAX = LS_W'(MAX_LOG_SIZE);

    typedef logic signed [Q_W-1:0] q62_t;

    typedef struct packed {
        q62_t re;
        q62_t im;
    } cplx_t;

    // partial products of one signed 64x64 product
    typedef struct packed {
        logic        [63:0] ll;
        logic signed [64:0] lh;
        logic signed [64:0] hl;
        logic signed [63:0] hh;
    } pp_t;

    typedef struct packed {
        logic [NSTEP-1:0] lo;
        logic [2:0]       hi;
        logic             swap;
        logic             bypass;
        logic             err;
        cplx_t            dir;
    } side_t;

    // -Re(w-1) mantissas, exp -(10+2t); Im(w-1) mantissas, exp -(5+t)
    localparam logic [63:0] OMC_RE [0:22] = '{
        64'h13BC390D250439, 64'h13BCFBD9979A27, 64'h13BD2C8DA49511, 64'h13BD38BAB6D94C,
        64'h13BD3BC5FC5AB4, 64'h13BD3C88CDCA13, 64'h13BD3CB98226DC, 64'h13BD3CC5AF3E1D,
        64'h13BD3CC8BA83EE, 64'h13BD3CC97D5562, 64'h13BD3CC9AE09BF, 64'h13BD3CC9BA36D7,
        64'h13BD3CC9BD421C, 64'h13BD3CC9BE04EE, 64'h13BD3CC9BE35A2, 64'h13BD3CC9BE41CF,
        64'h13BD3CC9BE44DB, 64'h13BD3CC9BE459D, 64'h13BD3CC9BE45CE, 64'h13BD3CC9BE45DA,
        64'h13BD3CC9BE45DD, 64'h13BD3CC9BE45DE, 64'h13BD3CC9BE45DE
    };
    localparam logic [63:0] OMC_IM [0:22] = '{
        64'h191F65F10DD814, 64'h192155F7A3667E, 64'h1921D1FCDEC784, 64'h1921F0FE670071,
        64'h1921F8BECCA4BA, 64'h1921FAAEE6472E, 64'h1921FB2AECB360, 64'h1921FB49EE4EA6,
        64'h1921FB51AEB57C, 64'h1921FB539ECF31, 64'h1921FB541AD59E, 64'h1921FB5439D73A,
        64'h1921FB544197A1, 64'h1921FB544387BA, 64'h1921FB544403C1, 64'h1921FB544422C2,
        64'h1921FB54442A83, 64'h1921FB54442C73, 64'h1921FB54442CEF, 64'h1921FB54442D0E,
        64'h1921FB54442D16, 64'h1921FB54442D18, 64'h1921FB54442D18
    };

    localparam logic [63:0] CIR_RE_M [0:8] = '{
        64'h10000000000000, 64'h1FD88DA3D12526, 64'h1F6297CFF75CB0, 64'h1E9F4156C62DDA,
        64'h1D906BCF328D46, 64'h1C38B2F180BDB1, 64'h1A9B66290EA1A3, 64'h18BC806B151741,
        64'h16A09E667F3BCD
    };
    localparam logic [3:0] CIR_RE_E [0:8] = '{4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1};
    localparam logic [63:0] CIR_IM_M [0:8] = '{
        64'h0,              64'h1917A6BC29B42C, 64'h18F8B83C69A60B, 64'h1294062ED59F06,
        64'h187DE2A6AEA963, 64'h1E2B5D3806F63B, 64'h11C73B39AE68C8, 64'h144CF325091DD6,
        64'h16A09E667F3BCD
    };
    localparam logic [3:0] CIR_IM_E [0:8] = '{4'd0, 4'd4, 4'd3, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1};

    // exp(2 pi i t/64), t <= 8; all exponents here give exact left shifts
    function automatic cplx_t cir_root(logic [3:0] t);
        cplx_t r;
        logic [3:0] ti;
        ti = (t > 4'd8) ? 4'd8 : t;
        r.re = q62_t'(CIR_RE_M[ti] << (4'd10 - CIR_RE_E[ti]));
        r.im = q62_t'(CIR_IM_M[ti] << (4'd10 - CIR_IM_E[ti]));
        return r;
    endfunction

    // exp(2 pi i/2^(t+7)) - 1 in Q1.62, rounded to nearest, ties away from zero
    function automatic cplx_t omc_x(logic [4:0] t);
        cplx_t r;
        logic [63:0] mr;
        logic [63:0] mi;
        logic [63:0] v;
        logic [5:0]  s;
        mr = '0;
        mi = '0;
        if (t < 5'd23)
        begin
            mr = OMC_RE[t];
            mi = OMC_IM[t];
        end
        s = {t, 1'b0};
        if (s == 6'd0)
            v = mr;
        else
            v = (mr + (64'd1 << (s - 6'd1))) >> s;
        r.re = q62_t'(64'd0 - v);
        if (t <= 5'd5)
            v = mi << (5'd5 - t);
        else
            v = (mi + (64'd1 << (t - 5'd6))) >> (t - 5'd5);
        r.im = q62_t'(v);
        return r;
    endfunction

    function automatic pp_t pp_make(q62_t a, q62_t b);
        pp_t r;
        logic signed [32:0] al;
        logic signed [32:0] bl;
        logic signed [31:0] ah;
        logic signed [31:0] bh;
        al = $signed({1'b0, a[31:0]});
        bl = $signed({1'b0, b[31:0]});
        ah = $signed(a[63:32]);
        bh = $signed(b[63:32]);
        r.ll = 64'(a[31:0]) * 64'(b[31:0]);
        r.lh = 65'(al) * 65'(bh);
        r.hl = 65'(ah) * 65'(bl);
        r.hh = 64'(ah) * 64'(bh);
        return r;
    endfunction

    // exact signed product, rounded half-up to Q1.62
    function automatic q62_t pp_round(pp_t p);
        logic signed [127:0] s;
        s = (128'(p.hh) <<< 64) + (128'(p.lh) <<< 32) + (128'(p.hl) <<< 32)
            + $signed(128'(p.ll)) + $signed(128'd1 << 61);
        return q62_t'(s[125:62]);
    endfunction

endpackage

>>> hw/rtl/ftr_if.sv
interface ftr_req_if;
    logic                      valid;
    logic                      ready;
    logic [ftr_pkg::IDX_W-1:0] index;
    modport source (output valid, output index, input ready);
    modport sink   (input valid, input index, output ready);
endinterface

interface ftr_rsp_if;
    logic                  valid;
    logic                  ready;
    logic signed [63:0]    real_part;
    logic signed [63:0]    imag_part;
    logic                  index_error;
    modport source (output valid, output real_part, output imag_part, output index_error,
                    input ready);
    modport sink   (input valid, input real_part, input imag_part, input index_error,
                    output ready);
endinterface

interface ftr_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [ftr_pkg::LS_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ftr_front.sv
module ftr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [ftr_pkg::IDX_W-1:0] k,
    input  logic [ftr_pkg::LS_W-1:0]  nc,
    output logic                      out_valid,
    output ftr_pkg::side_t            side
);
    import ftr_pkg::*;

    logic          valid_reg;
    side_t         side_reg;
    side_t         side_next;
    logic [18:0]   quarter;
    logic [18:0]   half;
    logic [17:0]   kk;
    logic [17:0]   t_full;
    logic [3:0]    t6;
    logic [4:0]    m;
    logic [17:0]   lo_full;

    always_comb
    begin
        quarter = 19'd1 << (nc - LS_W'(2));
        half    = (nc >= LS_W'(3)) ? (19'd1 << (nc - LS_W'(3))) : 19'd0;
        side_next = '0;
        side_next.err  = ({1'b0, k} >= quarter);
        side_next.swap = (nc != LS_W'(2)) && ({1'b0, k} > half);
        kk = side_next.swap ? 18'(quarter - {1'b0, k}) : k;
        // small sizes: direct entry of the eighth-circle table
        t_full = kk << (LS_W'(6) - nc);
        t6 = (t_full[3:0] > 4'd8) ? 4'd8 : t_full[3:0];
        m = nc - LS_W'(6);
        lo_full = kk & ((18'd1 << m) - 18'd1);
        side_next.lo = NSTEP'(lo_full);
        side_next.hi = 3'(kk >> m);
        side_next.bypass = 1'b1;
        priority if (side_next.err)
        begin
            side_next.swap = 1'b0;
            side_next.lo   = '0;
            side_next.dir  = '0;
        end
        else if (nc == LS_W'(2))
        begin
            side_next.lo  = '0;
            side_next.dir = cir_root(4'd0);
        end
        else if ({1'b0, k} == half)
        begin
            side_next.lo  = '0;
            side_next.dir = cir_root(4'd8);
        end
        else if (nc <= LS_W'(6))
        begin
            side_next.lo  = '0;
            side_next.dir = cir_root(t6);
        end
        else
        begin
            side_next.bypass = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            side_reg <= side_next;
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;

endmodule

>>> hw/rtl/ftr_cmul.sv
module ftr_cmul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  ftr_pkg::cplx_t a,
    input  ftr_pkg::cplx_t b,
    input  ftr_pkg::cplx_t add0,
    input  ftr_pkg::cplx_t add1,
    input  logic           en,
    input  ftr_pkg::side_t side_in,
    output logic           out_valid,
    output ftr_pkg::cplx_t res,
    output ftr_pkg::side_t side_out
);
    import ftr_pkg::*;

    // stage A: 32-bit partial products
    logic  va_reg;
    pp_t   rr_reg;
    pp_t   ii_reg;
    pp_t   ri_reg;
    pp_t   ir_reg;
    cplx_t add0_reg;
    cplx_t add1_reg;
    logic  en_reg;
    side_t sa_reg;
    // stage B: rounded sums
    logic  vb_reg;
    cplx_t res_reg;
    cplx_t res_next;
    side_t sb_reg;

    always_comb
    begin
        res_next = add1_reg;
        if (en_reg)
        begin
            res_next.re = add0_reg.re + add1_reg.re + (pp_round(rr_reg) - pp_round(ii_reg));
            res_next.im = add0_reg.im + add1_reg.im + (pp_round(ri_reg) + pp_round(ir_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rr_reg   <= pp_make(a.re, b.re);
            ii_reg   <= pp_make(a.im, b.im);
            ri_reg   <= pp_make(a.re, b.im);
            ir_reg   <= pp_make(a.im, b.re);
            add0_reg <= add0;
            add1_reg <= add1;
            en_reg   <= en;
            sa_reg   <= side_in;
            res_reg  <= res_next;
            sb_reg   <= sa_reg;
        end
    end

    assign out_valid = vb_reg;
    assign res       = res_reg;
    assign side_out  = sb_reg;

endmodule

>>> hw/rtl/fft_twiddle_root_generator_top.sv
// channel | dir | payload                              | handshake
// req     | in  | index[17:0]                          | valid/ready
// rsp     | out | real_part, imag_part (Q1.62), err    | valid/ready
// cfg     | in  | data[4:0] -> log_size                | valid/ready, ready tied high
//
// One word per cycle in and out while the output is taken: decode stage, 14 fold
// stages (partial products, then round and add), the final c[hi]*(1+e) product
// in the same two steps, one output register.
// Reset clears all valid bits and sets log_size to 10.
// Stall: the whole pipe holds while the output word waits and is not taken.
module fft_twiddle_root_generator_top (
    input  logic clk,
    input  logic rst_n,
    ftr_req_if.sink   req,
    ftr_rsp_if.source rsp,
    ftr_cfg_if.sink   cfg
);
    import ftr_pkg::*;

    logic [LS_W-1:0] log_size_reg;
    logic [LS_W-1:0] nc;
    logic            adv;

    logic            vs   [0:NSTEP];
    cplx_t           es   [0:NSTEP];
    side_t           sd   [0:NSTEP];

    logic            fin_valid;
    cplx_t           fin_res;
    side_t           fin_side;
    cplx_t           c_hi;

    logic            out_valid_reg;
    q62_t            re_reg;
    q62_t            im_reg;
    logic            err_reg;
    cplx_t           pick;

    // config: always taken, item traffic is idle by contract
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            log_size_reg <= LOG_SIZE_RST;
        else if (cfg.valid)
            log_size_reg <= cfg.data;
    end

    always_comb
    begin
        if (log_size_reg < LOG_SIZE_MIN)
            nc = LOG_SIZE_MIN;
        else if (log_size_reg > LOG_SIZE_MAX)
            nc = LOG_SIZE_MAX;
        else
            nc = log_size_reg;
    end

    // global advance: pipe moves unless the output word is held
    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    ftr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req.valid),
        .k         (req.index),
        .nc        (nc),
        .out_valid (vs[0]),
        .side      (sd[0])
    );

    assign es[0] = '0;

    // fold stage j handles bit j of lo: e = x + e + x*e, x for t = m-j-1
    for (genvar j = 0; j < NSTEP; j++)
    begin : g_fold
        cplx_t x_reg;

        // x follows log_size only; registered so the multiplier sees a flop
        always_ff @(posedge clk)
        begin
            x_reg <= omc_x(LS_W'(nc - LS_W'(7 + j)));
        end

        ftr_cmul u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (vs[j]),
            .a         (x_reg),
            .b         (es[j]),
            .add0      (x_reg),
            .add1      (es[j]),
            .en        (sd[j].lo[j]),
            .side_in   (sd[j]),
            .out_valid (vs[j+1]),
            .res       (es[j+1]),
            .side_out  (sd[j+1])
        );
    end

    // root = c[hi] + c[hi]*e
    assign c_hi = cir_root({1'b0, sd[NSTEP].hi});

    ftr_cmul u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vs[NSTEP]),
        .a         (c_hi),
        .b         (es[NSTEP]),
        .add0      (c_hi),
        .add1      ('0),
        .en        (1'b1),
        .side_in   (sd[NSTEP]),
        .out_valid (fin_valid),
        .res       (fin_res),
        .side_out  (fin_side)
    );

    // direct entries (errors, small sizes, pi/4) skip the fold result;
    // mirrored half swaps the parts
    assign pick = fin_side.bypass ? fin_side.dir : fin_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= fin_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            re_reg  <= fin_side.swap ? pick.im : pick.re;
            im_reg  <= fin_side.swap ? pick.re : pick.im;
            err_reg <= fin_side.err;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.real_part   = re_reg;
    assign rsp.imag_part   = im_reg;
    assign rsp.index_error = err_reg;

endmodule

>>> test/ftr_root_checker.sv
module ftr_root_checker
    import ftr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  logic [IDX_W-1:0] req_index,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  logic [63:0]      rsp_real,
    input  logic [63:0]      rsp_imag,
    input  logic             rsp_err,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [LS_W-1:0]  cfg_data,
    output int               fail_count,
    output int               roots_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] re;
        logic [63:0] im;
        logic        err;
    } root_word_t;

    root_word_t  roots_due [$];
    logic [4:0]  size_reg;

    function automatic logic [63:0] mant_to_q(logic [63:0] mant, int e, bit neg);
        logic [63:0] v;
        if (e <= 10)
            v = mant << (10 - e);
        else
            v = (mant + (64'd1 << (e - 11))) >> (e - 10);
        return neg ? 64'd0 - v : v;
    endfunction

    // exact signed product rounded half-up to Q1.62
    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic signed [127:0] p;
        p = 128'(signed'(a)) * 128'(signed'(b));
        p = p + (128'sd1 <<< 61);
        return p[125:62];
    endfunction

    function automatic void eighth_root(int t, output logic [63:0] re, output logic [63:0] im);
        if (t > 8)
            t = 8;
        re = mant_to_q(CIR_RE_M[t], CIR_RE_E[t], 0);
        im = mant_to_q(CIR_IM_M[t], CIR_IM_E[t], 0);
    endfunction

    function automatic void octant_root(int n, int k, output logic [63:0] re,
                                        output logic [63:0] im);
        int m;
        int t;
        logic [63:0] er, ei, xr, xi, pr, pim, cr, ci;
        er = '0;
        ei = '0;
        if (n <= 6)
        begin
            eighth_root((k << (6 - n)) & 15, re, im);
            return;
        end
        m = n - 6;
        for (int j = 0; j < m; j++)
            if ((k >> j) & 1)
            begin
                t   = m - j - 1;
                xr  = mant_to_q(OMC_RE[t], 10 + 2 * t, 1);
                xi  = mant_to_q(OMC_IM[t], 5 + t, 0);
                pr  = qmul(xr, er) - qmul(xi, ei);
                pim = qmul(xr, ei) + qmul(xi, er);
                er  = xr + (er + pr);
                ei  = xi + (ei + pim);
            end
        eighth_root((k >> m) & 7, cr, ci);
        re = cr + (qmul(cr, er) - qmul(ci, ei));
        im = ci + (qmul(cr, ei) + qmul(ci, er));
    endfunction

    function automatic root_word_t twiddle_of(logic [4:0] ls, logic [IDX_W-1:0] idx);
        root_word_t w;
        int n;
        int k;
        int quarter;
        int half;
        n = ls;
        k = idx;
        if (n < 2)
            n = 2;
        if (n > MAX_LOG_SIZE)
            n = MAX_LOG_SIZE;
        quarter = 1 << (n - 2);
        w.re  = '0;
        w.im  = '0;
        w.err = 1'b0;
        if (k >= quarter)
            w.err = 1'b1;
        else if (n == 2)
            w.re = mant_to_q(CIR_RE_M[0], CIR_RE_E[0], 0);
        else
        begin
            half = 1 << (n - 3);
            if (k == half)
                eighth_root(8, w.re, w.im);
            else if (k > half)
                octant_root(n, quarter - k, w.im, w.re);   // mirrored, parts swapped
            else
                octant_root(n, k, w.re, w.im);
        end
        return w;
    endfunction

    assign roots_pending = roots_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        root_word_t exp_w;
        if (!rst_n)
        begin
            size_reg   <= LOG_SIZE_RST;
            fail_count <= 0;
            roots_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
            if (req_valid && req_ready)
                roots_due.push_back(twiddle_of(size_reg, req_index));
            if (rsp_valid && rsp_ready)
            begin
                if (roots_due.size() == 0)
                begin
                    $display("%0t: unexpected word re=%h im=%h err=%b", $time,
                             rsp_real, rsp_imag, rsp_err);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = roots_due.pop_front();
                    if (exp_w.re !== rsp_real || exp_w.im !== rsp_imag
                        || exp_w.err !== rsp_err)
                    begin
                        $display("%0t: mismatch expected re=%h im=%h err=%b got re=%h im=%h err=%b",
                                 $time, exp_w.re, exp_w.im, exp_w.err,
                                 rsp_real, rsp_imag, rsp_err);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> test/fft_twiddle_root_generator_top_tb.sv
module fft_twiddle_root_generator_top_tb;
    import ftr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT   = 32;     // used as drain margin
    localparam int STALL_CAP  = 20000;  // cycles with no word moving

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ftr_req_if req ();
    ftr_rsp_if rsp ();
    ftr_cfg_if cfg ();

    int  fail_count;
    int  roots_pending;
    bit  quiet;           // final stretch: no idling on either side
    int  idle_cycles;

    always #5 clk = ~clk;

    fft_twiddle_root_generator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    ftr_root_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req.valid),
        .req_ready     (req.ready),
        .req_index     (req.index),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_real      (rsp.real_part),
        .rsp_imag      (rsp.imag_part),
        .rsp_err       (rsp.index_error),
        .cfg_valid     (cfg.valid),
        .cfg_ready     (cfg.ready),
        .cfg_data      (cfg.data),
        .fail_count    (fail_count),
        .roots_pending (roots_pending)
    );

    initial
    begin
        req.valid = 1'b0;
        req.index = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data  = '0;
    end

    // Receiver: ready drops in random bursts, none once quiet.
    initial
    begin
        int burst;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 17);
                rsp.ready <= 1'b0;
                repeat (burst) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: counts cycles where no word moves on any channel.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_CAP)
        begin
            $display("fft_twiddle_root_generator_top_tb: FAIL");
            $finish;
        end
    end

    // One index word; the sender may gap first.
    task automatic send_index(logic [IDX_W-1:0] k);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.index <= k;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Wait for the pipe to drain, then write log_size.
    task automatic set_log_size(logic [LS_W-1:0] ls);
        req.valid <= 1'b0;
        @(posedge clk);
        while (roots_pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data  <= ls;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Mostly in-range indices, plenty at the octant and quadrant edges.
    function automatic logic [IDX_W-1:0] pick_index(int n);
        int q;
        int sel;
        q = 1 << (n - 2);
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return IDX_W'($urandom);
        if (sel == 1)
            return IDX_W'(q + $urandom_range(0, 3));
        if (sel == 2 && n >= 3)
            return IDX_W'((q >> 1) + $urandom_range(0, 2) - 1);
        if (sel == 3)
            return IDX_W'(q - 1);
        return IDX_W'($urandom_range(0, q - 1));
    endfunction

    initial
    begin
        int sizes [];
        int n;
        sizes = '{2, 3, 20, 0, 31, 7, 6, 15, 4, 12};
        quiet = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: octant and quadrant edges at the reset log_size of 10, then n=2, n=3 and n=20 corners.
        send_index(0);
        send_index(1);
        send_index(127);
        send_index(128);
        send_index(129);
        send_index(255);
        send_index(256);
        send_index('1);
        set_log_size(2);
        send_index(0);
        send_index(1);
        set_log_size(3);
        send_index(0);
        send_index(1);
        send_index(2);
        set_log_size(20);
        send_index(0);
        send_index(18'h1FFFF);
        send_index(18'h20000);
        send_index(18'h20001);
        send_index(18'h2AAAA);
        send_index(18'h15555);
        send_index(18'h3FFFF);

        // Random phases across sizes, out-of-range sizes saturate.
        foreach (sizes[s])
        begin
            set_log_size(LS_W'(sizes[s]));
            n = sizes[s] < 2 ? 2 : (sizes[s] > MAX_LOG_SIZE ? MAX_LOG_SIZE : sizes[s]);
            if (s == sizes.size() - 1)
                quiet = 1'b1;
            for (int i = 0; i < 80; i++)
            begin
                send_index(pick_index(n));
                // sender holds off until the pipe has emptied
                if (i == 40 && s == 2)
                begin
                    req.valid <= 1'b0;
                    @(posedge clk);
                    while (roots_pending != 0)
                        @(posedge clk);
                end
            end
        end
        req.valid <= 1'b0;

        while (roots_pending != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        if (fail_count == 0)
            $display("fft_twiddle_root_generator_top_tb: PASS");
        else
            $display("fft_twiddle_root_generator_top_tb: FAIL");
        $finish;
    end
endmodule
